### sv/three_rotor_letter_cipher_defines.svh
// ----------------------------------------------------------------------------
// three_rotor_letter_cipher_defines
// assertion macros used by the rotor cipher checker
// ----------------------------------------------------------------------------
`ifndef THREE_ROTOR_LETTER_CIPHER_DEFINES_SVH
`define THREE_ROTOR_LETTER_CIPHER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define TRLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trlc assertion failed");

// next-cycle implication, disabled while reset is held
`define TRLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trlc assertion failed");

`endif

### sv/trlc_pkg.sv
// ----------------------------------------------------------------------------
// trlc_pkg
// constants and types for the three rotor letter cipher
// ----------------------------------------------------------------------------
package trlc_pkg;

  localparam int unsigned TRLC_ALPHABET_SIZE = 26;
  localparam int unsigned TRLC_NUM_ROTORS    = 3;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ENTRY_W = 5;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned POS_W   = 5;
  // table entry plus offset, before the mod reduction
  localparam int unsigned SUM_W     = ENTRY_W + 1;
  localparam int unsigned LUT_DEPTH = 2 ** SUM_W;

  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'd65;
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'd90;
  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'd97;
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'd122;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_CIPHER = 1'b1
  } op_e;

endpackage

### sv/three_rotor_letter_cipher.sv
// ----------------------------------------------------------------------------
// three_rotor_letter_cipher
// rotor substitution cipher on letter bytes with odometer offset stepping
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o, one beat per item. op_i = load
//   writes entry_value_i into rotor rotor_select_i at table_position_i and
//   gives no result. op_i = cipher sends char_in_i through all rotor tables
//   and gives one result beat on the output channel.
//   output channel: out_valid_o / out_stall_i, char_out_o held while stalled.
//   a result is registered and appears in the cycle after its input beat is accepted.
//   throughput: one item per cycle unless stalled; the whole rotor chain and
//   the offset update are evaluated in the accept cycle into their registers.
//   in_stall_o is high only while a result waits and out_stall_i is high.
//   reset clears all offsets and the output valid; rotor tables are not
//   cleared and must be loaded before letters are sent.
//   non-letter bytes pass unchanged and do not step the offsets.
// ----------------------------------------------------------------------------
module three_rotor_letter_cipher
  import trlc_pkg::*;
#(
  parameter int unsigned ALPHABET_SIZE = TRLC_ALPHABET_SIZE,
  parameter int unsigned NUM_ROTORS    = TRLC_NUM_ROTORS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [SEL_W-1:0]  rotor_select_i,
  input  logic [POS_W-1:0]  table_position_i,
  input  logic [ENTRY_W-1:0] entry_value_i,
  input  logic [CHAR_W-1:0] char_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] char_out_o
);

  localparam int unsigned IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [IDX_W-1:0] OFF_LAST = IDX_W'(ALPHABET_SIZE - 1);

  logic                in_acc;
  logic                load_acc;
  logic                ciph_acc;
  logic                letter_acc;
  logic                pos_ok;
  logic                is_upper;
  logic                is_lower;
  logic                is_letter;
  logic [CHAR_W-1:0]   base;
  logic [ENTRY_W-1:0]  chain_v [NUM_ROTORS+1];
  logic [CHAR_W-1:0]   cipher_char;
  logic [IDX_W-1:0]    mod_lut [LUT_DEPTH];
  logic [IDX_W-1:0]    offs_q [NUM_ROTORS];
  logic [IDX_W-1:0]    offs_d [NUM_ROTORS];
  logic [NUM_ROTORS-1:0] step;
  logic                out_valid_q;
  logic                out_valid_d;
  logic [CHAR_W-1:0]   char_out_q;
  logic [CHAR_W-1:0]   char_out_d;

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (op_e'(op_i) == OP_LOAD);
  assign ciph_acc   = in_acc && (op_e'(op_i) == OP_CIPHER);
  assign letter_acc = ciph_acc && is_letter;
  assign pos_ok     = 32'(table_position_i) < ALPHABET_SIZE;

  // letter classification
  assign is_upper  = (char_in_i >= UPPER_FIRST) && (char_in_i <= UPPER_LAST);
  assign is_lower  = (char_in_i >= LOWER_FIRST) && (char_in_i <= LOWER_LAST);
  assign is_letter = is_upper || is_lower;
  assign base      = is_upper ? UPPER_FIRST : LOWER_FIRST;
  assign chain_v[0] = ENTRY_W'(char_in_i - base);

  // constant mod table for entry plus offset
  for (genvar i = 0; i < LUT_DEPTH; i++) begin : g_mod_lut
    assign mod_lut[i] = IDX_W'(i % ALPHABET_SIZE);
  end

  // one table per rotor, each read at a single place in the chain
  for (genvar r = 0; r < NUM_ROTORS; r++) begin : g_rotor
    logic [ENTRY_W-1:0] tbl_q [ALPHABET_SIZE];
    logic [SUM_W-1:0]   sum;
    logic [IDX_W-1:0]   rd_idx;
    logic               wr_en;

    assign wr_en = load_acc && pos_ok && (32'(rotor_select_i) == r);

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        tbl_q[table_position_i[IDX_W-1:0]] <= entry_value_i;
      end
    end

    assign sum          = SUM_W'(chain_v[r]) + SUM_W'(offs_q[r]);
    assign rd_idx       = mod_lut[sum];
    assign chain_v[r+1] = tbl_q[rd_idx];
  end

  assign cipher_char = base + CHAR_W'(chain_v[NUM_ROTORS]);

  // odometer stepping
  always_comb begin
    step[0] = letter_acc;
    for (int r = 1; r < NUM_ROTORS; r++) begin
      step[r] = step[r-1] && (offs_q[r-1] == OFF_LAST);
    end
    for (int r = 0; r < NUM_ROTORS; r++) begin
      offs_d[r] = offs_q[r];
      if (step[r]) begin
        offs_d[r] = (offs_q[r] == OFF_LAST) ? '0 : offs_q[r] + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROTORS; r++) begin
        offs_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < NUM_ROTORS; r++) begin
        offs_q[r] <= offs_d[r];
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    char_out_d  = char_out_q;
    if (ciph_acc) begin
      out_valid_d = 1'b1;
      char_out_d  = is_letter ? cipher_char : char_in_i;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_out_q <= char_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_out_q;

endmodule

### sv/trlc_checker.sv
// ----------------------------------------------------------------------------
// trlc_checker
// port-level checks for the three rotor letter cipher
// ----------------------------------------------------------------------------
`include "three_rotor_letter_cipher_defines.svh"

module trlc_checker
  import trlc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               op_i,
  input logic [SEL_W-1:0]   rotor_select_i,
  input logic [POS_W-1:0]   table_position_i,
  input logic [ENTRY_W-1:0] entry_value_i,
  input logic [CHAR_W-1:0]  char_in_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CHAR_W-1:0]  char_out_o
);

  logic in_acc;
  logic ciph_acc;
  logic pass_acc;
  logic load_beat;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign ciph_acc = in_acc && (op_e'(op_i) == OP_CIPHER);
  assign pass_acc = ciph_acc
    && !((char_in_i >= UPPER_FIRST) && (char_in_i <= UPPER_LAST))
    && !((char_in_i >= LOWER_FIRST) && (char_in_i <= LOWER_LAST));
  // load fields only matter on load beats
  assign load_beat = in_acc && (op_e'(op_i) == OP_LOAD)
    && ((rotor_select_i != '0) || (table_position_i != '0) || (entry_value_i != '0)
        || (rotor_select_i == '0));

  `TRLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(char_out_o))
  `TRLC_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  `TRLC_ASSERT_NXT(a_cipher_result, clk_i, rst_ni, ciph_acc, out_valid_o)
  `TRLC_ASSERT_NXT(a_pass_through, clk_i, rst_ni, pass_acc, char_out_o == $past(char_in_i))
  `TRLC_ASSERT_IMP(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(ciph_acc) && !$past(load_beat))

endmodule

bind three_rotor_letter_cipher trlc_checker u_trlc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .op_i             (op_i),
  .rotor_select_i   (rotor_select_i),
  .table_position_i (table_position_i),
  .entry_value_i    (entry_value_i),
  .char_in_i        (char_in_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .char_out_o       (char_out_o)
);
